[hw/rtl/guid_text_parser_unit_defines.svh]
// Assertion macros shared by the GUID text parser checker.
`ifndef GUID_TEXT_PARSER_UNIT_DEFINES_SVH
`define GUID_TEXT_PARSER_UNIT_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define GTP_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gtp check failed");

// Next-cycle implication that also holds across reset.
`define GTP_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("gtp check failed");

`endif

[hw/rtl/gtp_pkg.sv]
// Types, constants and helper functions for the GUID text parser.
`default_nettype none
package gtp_pkg;

  localparam int LEN_BRACE_N = 68;

  localparam logic [6:0] LEN_PLAIN  = 7'd32;
  localparam logic [6:0] LEN_HYPHEN = 7'd36;
  localparam logic [6:0] LEN_BRACE  = 7'd68;
  localparam logic [6:0] POS_SAT    = 7'd69;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  // Marker in the brace map for a hex digit position.
  localparam logic [7:0] CH_HEX    = 8'h68;

  localparam logic [1:0] MODE_DETECT = 2'd0;
  localparam logic [1:0] MODE_PLAIN  = 2'd1;
  localparam logic [1:0] MODE_HYPHEN = 2'd2;
  localparam logic [1:0] MODE_BRACE  = 2'd3;

  localparam logic [1:0] LAY_PLAIN  = 2'd0;
  localparam logic [1:0] LAY_HYPHEN = 2'd1;
  localparam logic [1:0] LAY_BRACE  = 2'd2;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_LEN = 2'd1;
  localparam logic [1:0] ST_LIT = 2'd2;
  localparam logic [1:0] ST_HEX = 2'd3;

  localparam logic [7:0] BRACE_MAP [LEN_BRACE_N] = '{
    CH_LBRACE, CH_ZERO, CH_X,
    CH_HEX, CH_HEX, CH_HEX, CH_HEX, CH_HEX, CH_HEX, CH_HEX, CH_HEX,
    CH_COMMA, CH_ZERO, CH_X, CH_HEX, CH_HEX, CH_HEX, CH_HEX,
    CH_COMMA, CH_ZERO, CH_X, CH_HEX, CH_HEX, CH_HEX, CH_HEX,
    CH_COMMA, CH_LBRACE,
    CH_ZERO, CH_X, CH_HEX, CH_HEX, CH_COMMA,
    CH_ZERO, CH_X, CH_HEX, CH_HEX, CH_COMMA,
    CH_ZERO, CH_X, CH_HEX, CH_HEX, CH_COMMA,
    CH_ZERO, CH_X, CH_HEX, CH_HEX, CH_COMMA,
    CH_ZERO, CH_X, CH_HEX, CH_HEX, CH_COMMA,
    CH_ZERO, CH_X, CH_HEX, CH_HEX, CH_COMMA,
    CH_ZERO, CH_X, CH_HEX, CH_HEX, CH_COMMA,
    CH_ZERO, CH_X, CH_HEX, CH_HEX,
    CH_RBRACE, CH_RBRACE
  };

  typedef struct packed {
    logic [6:0]   pos;
    logic [127:0] plain;
    logic [127:0] hyphen;
    logic [127:0] brace;
    logic [2:0]   layout_good;
    logic [2:0]   hex_good;
  } gtp_state_t;

  typedef struct packed {
    logic        parse_ok;
    logic [1:0]  status;
    logic [1:0]  layout;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [31:0] word_c;
    logic [31:0] word_d;
  } gtp_result_t;

  // Bit 4 flags a character that is not a hex digit; the nibble is then zero.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b0, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/gtp_accum.sv]
// Per-character state of the parser: position count, digit shifters, check bits.
`default_nettype none
module gtp_accum
  import gtp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] char_code,
  input  wire logic       is_last,
  output gtp_state_t      upd
);

  gtp_state_t state_r;
  gtp_state_t state_nxt;
  logic [4:0] nib;
  logic [7:0] bmap;

  always_comb begin
    upd  = state_r;
    nib  = hex_decode(char_code);
    bmap = CH_HEX;
    if (state_r.pos < LEN_BRACE) begin
      bmap = BRACE_MAP[state_r.pos];
    end
    if (char_code != CH_SPACE) begin
      if (state_r.pos < LEN_PLAIN) begin
        upd.plain = {state_r.plain[123:0], nib[3:0]};
        if (nib[4]) upd.hex_good[0] = 1'b0;
      end
      if (state_r.pos < LEN_HYPHEN) begin
        if (state_r.pos == 7'd8 || state_r.pos == 7'd13 ||
            state_r.pos == 7'd18 || state_r.pos == 7'd23) begin
          if (char_code != CH_HYPHEN) upd.layout_good[1] = 1'b0;
        end else begin
          upd.hyphen = {state_r.hyphen[123:0], nib[3:0]};
          if (nib[4]) upd.hex_good[1] = 1'b0;
        end
      end
      if (state_r.pos < LEN_BRACE) begin
        if (bmap == CH_HEX) begin
          upd.brace = {state_r.brace[123:0], nib[3:0]};
          if (nib[4]) upd.hex_good[2] = 1'b0;
        end else if (char_code != bmap) begin
          upd.layout_good[2] = 1'b0;
        end
      end
      if (state_r.pos < POS_SAT) upd.pos = state_r.pos + 7'd1;
    end
  end

  // Digit shifters are fully rewritten before any successful read, so only
  // the count and the check bits return to their start values.
  always_comb begin
    state_nxt = state_r;
    if (step) begin
      state_nxt = upd;
      if (is_last) begin
        state_nxt.pos         = '0;
        state_nxt.layout_good = '1;
        state_nxt.hex_good    = '1;
      end
    end
  end

  always_ff @(posedge clk) begin
    state_r.plain  <= state_nxt.plain;
    state_r.hyphen <= state_nxt.hyphen;
    state_r.brace  <= state_nxt.brace;
    if (!rst_n) begin
      state_r.pos         <= '0;
      state_r.layout_good <= '1;
      state_r.hex_good    <= '1;
    end else begin
      state_r.pos         <= state_nxt.pos;
      state_r.layout_good <= state_nxt.layout_good;
      state_r.hex_good    <= state_nxt.hex_good;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/gtp_verdict.sv]
// Picks the layout, ranks the faults and forms the result of a finished text.
`default_nettype none
module gtp_verdict
  import gtp_pkg::*;
(
  input  wire logic [1:0] layout_mode,
  input  gtp_state_t      st,
  output gtp_result_t     res
);

  logic [1:0]   lay;
  logic         len_ok;
  logic [127:0] digits;

  always_comb begin
    lay    = LAY_PLAIN;
    len_ok = 1'b0;
    unique case (layout_mode)
      MODE_DETECT: begin
        priority if (st.pos == LEN_PLAIN) begin
          lay = LAY_PLAIN;  len_ok = 1'b1;
        end else if (st.pos == LEN_HYPHEN) begin
          lay = LAY_HYPHEN; len_ok = 1'b1;
        end else if (st.pos == LEN_BRACE) begin
          lay = LAY_BRACE;  len_ok = 1'b1;
        end else begin
          lay = LAY_PLAIN;  len_ok = 1'b0;
        end
      end
      MODE_PLAIN: begin
        lay = LAY_PLAIN;  len_ok = (st.pos == LEN_PLAIN);
      end
      MODE_HYPHEN: begin
        lay = LAY_HYPHEN; len_ok = (st.pos == LEN_HYPHEN);
      end
      MODE_BRACE: begin
        lay = LAY_BRACE;  len_ok = (st.pos == LEN_BRACE);
      end
      default: begin
        lay = LAY_PLAIN;  len_ok = 1'b0;
      end
    endcase

    unique case (lay)
      LAY_PLAIN:  digits = st.plain;
      LAY_HYPHEN: digits = st.hyphen;
      default:    digits = st.brace;
    endcase

    priority if (!len_ok) begin
      res.status = ST_LEN;
    end else if (!st.layout_good[lay]) begin
      res.status = ST_LIT;
    end else if (!st.hex_good[lay]) begin
      res.status = ST_HEX;
    end else begin
      res.status = ST_OK;
    end

    res.parse_ok = (res.status == ST_OK);
    res.layout   = lay;
    res.word_a   = res.parse_ok ? digits[127:96] : 32'd0;
    res.word_b   = res.parse_ok ? digits[95:64]  : 32'd0;
    res.word_c   = res.parse_ok ? digits[63:32]  : 32'd0;
    res.word_d   = res.parse_ok ? digits[31:0]   : 32'd0;
  end

endmodule
`default_nettype wire

[hw/rtl/guid_text_parser_unit.sv]
// Top level of the GUID text parser: input stage, state, result register, APB register.
// A last character passes through the input register and then into the result register.
// Throughput: one character per cycle, one pass of position checks and nibble shifts each;
// a last character waits in the input register only while an earlier result is stalled.
// Reset (synchronous, rst_n low) empties both stages, clears the count and check bits,
// and sets layout_mode to detect by length.
`default_nettype none
module guid_text_parser_unit
  import gtp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_is_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_parse_ok,
  output logic [1:0]       out_status,
  output logic [1:0]       out_layout_found,
  output logic [31:0]      out_word_a,
  output logic [31:0]      out_word_b,
  output logic [31:0]      out_word_c,
  output logic [31:0]      out_word_d,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_char_r;
  logic        s1_last_r;
  logic        out_valid_r, out_valid_nxt;
  gtp_result_t res_r;
  gtp_result_t res;
  gtp_state_t  upd;
  logic [1:0]  mode_r, mode_nxt;
  logic        out_free;
  logic        s1_go;
  logic        in_take;
  logic        res_load;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;
  assign res_load = s1_go && s1_last_r;

  gtp_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_go),
    .char_code (s1_char_r),
    .is_last   (s1_last_r),
    .upd       (upd)
  );

  gtp_verdict u_verdict (
    .layout_mode (mode_r),
    .st          (upd),
    .res         (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    mode_nxt = mode_r;
    if (psel && penable && pwrite && pready && !paddr[2]) begin
      mode_nxt = pwdata[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_DETECT;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      mode_r      <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_char_code;
      s1_last_r <= in_is_last;
    end
    if (res_load) begin
      res_r <= res;
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {30'd0, mode_r};

  assign out_valid        = out_valid_r;
  assign out_parse_ok     = res_r.parse_ok;
  assign out_status       = res_r.status;
  assign out_layout_found = res_r.layout;
  assign out_word_a       = res_r.word_a;
  assign out_word_b       = res_r.word_b;
  assign out_word_c       = res_r.word_c;
  assign out_word_d       = res_r.word_d;

endmodule
`default_nettype wire

[hw/rtl/gtp_checker.sv]
// Port-level assertions for the GUID text parser and their bind to the top level.
`default_nettype none
`include "guid_text_parser_unit_defines.svh"
module gtp_checker
  import gtp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_parse_ok,
  input wire logic [1:0]  out_status,
  input wire logic [31:0] out_word_a,
  input wire logic [31:0] out_word_b,
  input wire logic [31:0] out_word_c,
  input wire logic [31:0] out_word_d
);

  logic [127:0] all_words;

  assign all_words = {out_word_a, out_word_b, out_word_c, out_word_d};

  `GTP_CHECK(a_out_hold, out_valid && out_stall, ##1 (out_valid && $stable(out_word_a)))
  `GTP_CHECK(a_ok_matches_status, out_valid, out_parse_ok == (out_status == ST_OK))
  `GTP_CHECK(a_fail_zero_words, out_valid && !out_parse_ok, all_words == 128'd0)
  `GTP_CHECK_NEXT(a_reset_empties, !rst_n, !out_valid)

endmodule

bind guid_text_parser_unit gtp_checker u_gtp_checker (.*);
`default_nettype wire
